FILE: src/ghv_pkg.sv
// Shared widths, register codes and types of the voxel heat map block.
package ghv_pkg;

    localparam int COORD_W    = 18;
    localparam int IDX_W      = 6;
    localparam int MAP_ENTRIES = 1 << IDX_W;
    localparam int SPREAD_W   = 16;
    localparam int HEAT_W     = 17;
    localparam int FRAC_W     = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 18;

    // normalization divider
    localparam int RANGE_W = COORD_W + 1;
    localparam int MAG_W   = COORD_W;
    localparam int QUO_W   = MAG_W + FRAC_W;
    localparam int G_W     = QUO_W + 1;

    // per-axis exponent
    localparam int POS_W     = 22;
    localparam int DIFF_W    = G_W + 1;
    localparam int DIST_W    = 19;
    localparam int DIST_CAP  = 262144;
    localparam int SQ_W      = 2 * DIST_W - 1;
    localparam int DEN_W     = 2 * SPREAD_W + 1;
    localparam int EXP_W     = 17;
    localparam int EXP_LIMIT = 78903;
    localparam int EXP_SAT   = EXP_LIMIT + 1;
    localparam int ESUM_W    = EXP_W + 2;

    // exp(-x) series
    localparam int NUM_TERMS   = 15;
    localparam int X_W         = EXP_W + 8;
    localparam int TERM_W      = 25;
    localparam int TERM_ONE    = 1 << 24;
    localparam int PROD_W      = TERM_W + X_W;
    localparam int PROD_SHIFT  = 24;
    localparam int P_W         = 26;
    localparam int RECIP_SHIFT = 28;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int RECIP_ONE   = 1 << RECIP_SHIFT;
    localparam int MUL_W       = P_W + RECIP_W;
    localparam int QK_W        = P_W + 4;
    localparam int SUM_W       = 28;
    localparam int ROUND_HALF  = 128;
    localparam int ROUND_SHIFT = 8;
    localparam int HEAT_ONE    = 65536;

    localparam logic [CFG_IDX_W-1:0] REG_X_LOW      = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X_HIGH     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Y_LOW      = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_HIGH     = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_LOW  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_HIGH = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPREAD_X   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPREAD_Y   = 4'd7;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [G_W-1:0]     gnorm_t;

    typedef struct packed {
        logic en;
        logic valid;
    } pipe_ctl_t;

endpackage

FILE: src/ghv_norm.sv
// Pipelined restoring divider that normalizes one raw coordinate to Q.16.
module ghv_norm
    import ghv_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  pipe_ctl_t        ctl,
    input  coord_t           raw,
    input  coord_t           low,
    input  logic [MAG_W-1:0] divisor,
    input  logic [IDX_W-1:0] tag_in,
    output logic             out_valid,
    output gnorm_t           g,
    output logic [IDX_W-1:0] tag_out
);

    logic [QUO_W:0]          v_reg;
    logic [MAG_W-1:0]        rem_reg [QUO_W+1];
    logic [QUO_W-1:0]        dq_reg  [QUO_W+1];
    logic                    neg_reg [QUO_W+1];
    logic [IDX_W-1:0]        tag_reg [QUO_W+1];
    logic [MAG_W-1:0]        rem_next [QUO_W];
    logic [QUO_W-1:0]        dq_next  [QUO_W];
    logic [MAG_W:0]          t_arr   [QUO_W];
    logic [MAG_W:0]          sub_arr [QUO_W];
    logic signed [RANGE_W-1:0] diff;
    logic [MAG_W-1:0]        mag;
    logic                    v_out_reg;
    gnorm_t                  g_reg;
    logic [IDX_W-1:0]        tag_out_reg;

    assign diff = RANGE_W'(raw) - RANGE_W'(low);
    assign mag  = diff[RANGE_W-1] ? MAG_W'(-diff) : MAG_W'(diff);

    // one quotient bit per stage
    always_comb
    begin
        for (int s = 0; s < QUO_W; s++)
        begin
            t_arr[s]   = {rem_reg[s], dq_reg[s][QUO_W-1]};
            sub_arr[s] = t_arr[s] - {1'b0, divisor};
            if (t_arr[s] >= {1'b0, divisor})
            begin
                rem_next[s] = sub_arr[s][MAG_W-1:0];
                dq_next[s]  = {dq_reg[s][QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[s] = t_arr[s][MAG_W-1:0];
                dq_next[s]  = {dq_reg[s][QUO_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg     <= '0;
            v_out_reg <= 1'b0;
        end
        else if (ctl.en)
        begin
            v_reg     <= {v_reg[QUO_W-1:0], ctl.valid};
            v_out_reg <= v_reg[QUO_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            rem_reg[0] <= '0;
            dq_reg[0]  <= {mag, {FRAC_W{1'b0}}};
            neg_reg[0] <= diff[RANGE_W-1];
            tag_reg[0] <= tag_in;
            for (int s = 0; s < QUO_W; s++)
            begin
                rem_reg[s+1] <= rem_next[s];
                dq_reg[s+1]  <= dq_next[s];
                neg_reg[s+1] <= neg_reg[s];
                tag_reg[s+1] <= tag_reg[s];
            end
            g_reg       <= neg_reg[QUO_W] ? -G_W'(dq_reg[QUO_W]) : G_W'(dq_reg[QUO_W]);
            tag_out_reg <= tag_reg[QUO_W];
        end
    end

    assign out_valid = v_out_reg;
    assign g         = g_reg;
    assign tag_out   = tag_out_reg;

endmodule

FILE: src/ghv_axis.sv
// Per-axis Gaussian exponent: distance, square and a saturating divide by 2 sigma^2.
module ghv_axis
    import ghv_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  pipe_ctl_t        ctl,
    input  gnorm_t           g,
    input  logic [POS_W-1:0] pos,
    input  logic [DEN_W-1:0] den,
    output logic             out_valid,
    output logic [EXP_W-1:0] e
);

    logic signed [DIFF_W-1:0] d_reg;
    logic [DIST_W-1:0]        m_reg;
    logic [SQ_W-1:0]          sq_reg;
    logic [DEN_W-1:0]         rem_reg [EXP_W+1];
    logic [EXP_W-1:0]         lo_reg  [EXP_W+1];
    logic                     ov_reg  [EXP_W+1];
    logic [EXP_W-1:0]         e_reg;
    logic [EXP_W+4:0]         v_reg;
    logic [DIFF_W-1:0]        dmag;
    logic [DEN_W-1:0]         rem_next [EXP_W];
    logic [EXP_W-1:0]         lo_next  [EXP_W];
    logic [DEN_W:0]           t_arr    [EXP_W];
    logic [DEN_W:0]           sub_arr  [EXP_W];

    assign dmag = d_reg[DIFF_W-1] ? DIFF_W'(-d_reg) : DIFF_W'(d_reg);

    always_comb
    begin
        for (int s = 0; s < EXP_W; s++)
        begin
            t_arr[s]   = {rem_reg[s], lo_reg[s][EXP_W-1]};
            sub_arr[s] = t_arr[s] - {1'b0, den};
            if (t_arr[s] >= {1'b0, den})
            begin
                rem_next[s] = sub_arr[s][DEN_W-1:0];
                lo_next[s]  = {lo_reg[s][EXP_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[s] = t_arr[s][DEN_W-1:0];
                lo_next[s]  = {lo_reg[s][EXP_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (ctl.en)
            v_reg <= {v_reg[EXP_W+3:0], ctl.valid};
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            d_reg  <= DIFF_W'($signed({1'b0, pos})) - DIFF_W'(g);
            m_reg  <= (dmag > DIFF_W'(DIST_CAP)) ? DIST_W'(DIST_CAP) : dmag[DIST_W-1:0];
            sq_reg <= SQ_W'(m_reg) * SQ_W'(m_reg);
            // quotient at or above 2^17 saturates; else the top part is already below den
            ov_reg[0]  <= sq_reg >= SQ_W'({den, 1'b0});
            rem_reg[0] <= sq_reg[DEN_W:1];
            lo_reg[0]  <= {sq_reg[0], {FRAC_W{1'b0}}};
            for (int s = 0; s < EXP_W; s++)
            begin
                rem_reg[s+1] <= rem_next[s];
                lo_reg[s+1]  <= lo_next[s];
                ov_reg[s+1]  <= ov_reg[s];
            end
            if (ov_reg[EXP_W] || (lo_reg[EXP_W] > EXP_W'(EXP_SAT)))
                e_reg <= EXP_W'(EXP_SAT);
            else
                e_reg <= lo_reg[EXP_W];
        end
    end

    assign out_valid = v_reg[EXP_W+4];
    assign e         = e_reg;

endmodule

FILE: src/ghv_nexp.sv
// Pipelined 16-term alternating series for exp(-E), rounded to Q1.16.
module ghv_nexp
    import ghv_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  pipe_ctl_t         ctl,
    input  logic [EXP_W-1:0]  e,
    input  logic              zero_in,
    output logic              out_valid,
    output logic [HEAT_W-1:0] val,
    output logic              zero_out
);

    logic [TERM_W-1:0]       c_term [NUM_TERMS+1];
    logic signed [SUM_W-1:0] c_sum  [NUM_TERMS+1];
    logic [X_W-1:0]          c_x    [NUM_TERMS+1];
    logic                    c_z    [NUM_TERMS+1];
    logic [NUM_TERMS:0]      c_v_reg;

    logic [P_W-1:0]          a_p   [NUM_TERMS];
    logic signed [SUM_W-1:0] a_sum [NUM_TERMS];
    logic [X_W-1:0]          a_x   [NUM_TERMS];
    logic                    a_z   [NUM_TERMS];
    logic [NUM_TERMS-1:0]    a_v_reg;

    logic [P_W-1:0]          b_q   [NUM_TERMS];
    logic [P_W-1:0]          b_p   [NUM_TERMS];
    logic signed [SUM_W-1:0] b_sum [NUM_TERMS];
    logic [X_W-1:0]          b_x   [NUM_TERMS];
    logic                    b_z   [NUM_TERMS];
    logic [NUM_TERMS-1:0]    b_v_reg;

    logic [RECIP_W-1:0]      recip_tab [NUM_TERMS];
    logic [PROD_W-1:0]       a_prod    [NUM_TERMS];
    logic signed [SUM_W-1:0] a_sum_next [NUM_TERMS];
    logic [MUL_W-1:0]        b_prod    [NUM_TERMS];
    logic [QK_W-1:0]         rem_arr   [NUM_TERMS];
    logic [TERM_W-1:0]       term_next [NUM_TERMS];

    logic signed [SUM_W-1:0] s1_reg;
    logic                    z1_reg;
    logic                    v1_reg;
    logic [HEAT_W-1:0]       val_reg;
    logic                    z2_reg;
    logic                    v2_reg;
    logic signed [SUM_W-1:0] last_term;
    logic [SUM_W-1:0]        rnd;
    logic [SUM_W-ROUND_SHIFT-1:0] shifted;

    // floor(2^28 / k) for the divide by k of each term
    for (genvar j = 0; j < NUM_TERMS; j++)
    begin : g_recip
        localparam int KV = j + 1;
        assign recip_tab[j] = RECIP_W'(RECIP_ONE / KV);
    end

    always_comb
    begin
        for (int j = 0; j < NUM_TERMS; j++)
        begin
            a_prod[j] = PROD_W'(c_term[j]) * PROD_W'(c_x[j]);
            if ((j & 1) != 0)
                a_sum_next[j] = c_sum[j] - SUM_W'($signed({1'b0, c_term[j]}));
            else
                a_sum_next[j] = c_sum[j] + SUM_W'($signed({1'b0, c_term[j]}));
            b_prod[j] = MUL_W'(a_p[j]) * MUL_W'(recip_tab[j]);
            // the reciprocal estimate is at most one low: correct once
            rem_arr[j] = QK_W'(b_p[j]) - QK_W'(b_q[j]) * QK_W'(j + 1);
            if (rem_arr[j] >= QK_W'(j + 1))
                term_next[j] = TERM_W'(b_q[j] + 1'b1);
            else
                term_next[j] = TERM_W'(b_q[j]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_v_reg <= '0;
            a_v_reg <= '0;
            b_v_reg <= '0;
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
        end
        else if (ctl.en)
        begin
            c_v_reg[0] <= ctl.valid;
            for (int j = 0; j < NUM_TERMS; j++)
            begin
                a_v_reg[j]   <= c_v_reg[j];
                b_v_reg[j]   <= a_v_reg[j];
                c_v_reg[j+1] <= b_v_reg[j];
            end
            v1_reg <= c_v_reg[NUM_TERMS];
            v2_reg <= v1_reg;
        end
    end

    assign last_term = SUM_W'($signed({1'b0, c_term[NUM_TERMS]}));
    assign rnd       = SUM_W'(s1_reg) + SUM_W'(ROUND_HALF);
    assign shifted   = rnd[SUM_W-1:ROUND_SHIFT];

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            c_term[0] <= TERM_W'(TERM_ONE);
            c_sum[0]  <= '0;
            c_x[0]    <= {e, 8'b0};
            c_z[0]    <= zero_in;
            for (int j = 0; j < NUM_TERMS; j++)
            begin
                a_p[j]   <= a_prod[j][PROD_SHIFT+P_W-1:PROD_SHIFT];
                a_sum[j] <= a_sum_next[j];
                a_x[j]   <= c_x[j];
                a_z[j]   <= c_z[j];
                b_q[j]   <= b_prod[j][RECIP_SHIFT+P_W-1:RECIP_SHIFT];
                b_p[j]   <= a_p[j];
                b_sum[j] <= a_sum[j];
                b_x[j]   <= a_x[j];
                b_z[j]   <= a_z[j];
                c_term[j+1] <= term_next[j];
                c_sum[j+1]  <= b_sum[j];
                c_x[j+1]    <= b_x[j];
                c_z[j+1]    <= b_z[j];
            end
            if ((NUM_TERMS & 1) != 0)
                s1_reg <= c_sum[NUM_TERMS] - last_term;
            else
                s1_reg <= c_sum[NUM_TERMS] + last_term;
            z1_reg <= c_z[NUM_TERMS];
            if (s1_reg < 0)
                val_reg <= '0;
            else if (shifted > (SUM_W-ROUND_SHIFT)'(HEAT_ONE))
                val_reg <= HEAT_W'(HEAT_ONE);
            else
                val_reg <= shifted[HEAT_W-1:0];
            z2_reg <= z1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign val       = val_reg;
    assign zero_out  = z2_reg;

endmodule

FILE: src/gaussian_heatmap_voxel.sv
// Top level of the 3-D Gaussian heat map voxel evaluator.
// One voxel word enters per cycle while in_ready is high and one heat word leaves
// per voxel, in order, passing through the per-axis normalizing divider (one
// quotient bit per stage), the per-axis exponent unit (distance, square and a
// 17-step saturating divide), the exponent sum register, the exp(-E) series
// (three stages per term: multiply, reciprocal multiply, correction) and the
// output register. A stall at the output is absorbed by a one-word skid register,
// so in_ready drops only once both the output and skid registers are full.
// Configuration writes are taken at any time (cfg_ready is always high) but must
// only be made while the pipeline is empty; derived values (ranges, 2 sigma^2)
// settle in the cycle after a write.
module gaussian_heatmap_voxel
    import ghv_pkg::*;
#(
    parameter int GRID_SIZE    = 64,
    parameter int DEPTH_LAYERS = 64,
    parameter int SPREAD_DEPTH = 3277
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  coord_t                joint_x,
    input  coord_t                joint_y,
    input  coord_t                joint_depth,
    input  logic [IDX_W-1:0]      column,
    input  logic [IDX_W-1:0]      row,
    input  logic [IDX_W-1:0]      layer,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [HEAT_W-1:0]     heat,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [DEN_W-1:0] DEN_Z =
        DEN_W'(2 * longint'(SPREAD_DEPTH) * longint'(SPREAD_DEPTH));

    // configuration registers
    coord_t                x_low_reg, x_high_reg, y_low_reg, y_high_reg;
    coord_t                depth_low_reg, depth_high_reg;
    logic [SPREAD_W-1:0]   spread_x_reg, spread_y_reg;

    // values derived from configuration
    logic signed [RANGE_W-1:0] range_x, range_y, range_z;
    logic [MAG_W-1:0]      div_x_reg, div_y_reg, div_z_reg;
    logic [DEN_W-1:0]      den_x_reg, den_y_reg;
    logic                  kill_reg;

    // grid position tables
    logic [POS_W-1:0]      map_tab   [MAP_ENTRIES];
    logic [POS_W-1:0]      layer_tab [MAP_ENTRIES];

    logic                  en;
    pipe_ctl_t             ctl_in, ctl_axis, ctl_axis_y, ctl_axis_z, ctl_sum;
    logic                  vx, vy, vz, vax, vay, vaz;
    gnorm_t                gx, gy, gz;
    logic [IDX_W-1:0]      tx, ty, tz;
    logic [EXP_W-1:0]      ex, ey, ez;
    logic [ESUM_W-1:0]     esum_reg;
    logic                  vsum_reg;
    logic                  pipe_valid;
    logic [HEAT_W-1:0]     pipe_val;
    logic                  pipe_zero;
    logic [HEAT_W-1:0]     pipe_heat;

    logic                  out_valid_reg, skid_valid_reg;
    logic [HEAT_W-1:0]     heat_reg, skid_heat_reg;

    for (genvar i = 0; i < MAP_ENTRIES; i++)
    begin : g_pos
        localparam int MAP_POS   = (i * (1 << FRAC_W)) / GRID_SIZE;
        localparam int LAYER_POS = (i * (1 << FRAC_W)) / (DEPTH_LAYERS - 1);
        assign map_tab[i]   = POS_W'(MAP_POS);
        assign layer_tab[i] = POS_W'(LAYER_POS);
    end

    // configuration writes; unknown indexes are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_low_reg      <= COORD_W'(0);
            x_high_reg     <= COORD_W'(65536);
            y_low_reg      <= COORD_W'(0);
            y_high_reg     <= COORD_W'(65536);
            depth_low_reg  <= COORD_W'(-65536);
            depth_high_reg <= COORD_W'(65536);
            spread_x_reg   <= SPREAD_W'(3277);
            spread_y_reg   <= SPREAD_W'(3277);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_X_LOW:      x_low_reg      <= cfg_data;
                REG_X_HIGH:     x_high_reg     <= cfg_data;
                REG_Y_LOW:      y_low_reg      <= cfg_data;
                REG_Y_HIGH:     y_high_reg     <= cfg_data;
                REG_DEPTH_LOW:  depth_low_reg  <= cfg_data;
                REG_DEPTH_HIGH: depth_high_reg <= cfg_data;
                REG_SPREAD_X:   spread_x_reg   <= cfg_data[SPREAD_W-1:0];
                REG_SPREAD_Y:   spread_y_reg   <= cfg_data[SPREAD_W-1:0];
                default:        ;
            endcase
        end
    end

    assign range_x = RANGE_W'(x_high_reg) - RANGE_W'(x_low_reg);
    assign range_y = RANGE_W'(y_high_reg) - RANGE_W'(y_low_reg);
    assign range_z = RANGE_W'(depth_high_reg) - RANGE_W'(depth_low_reg);

    // register derived constants; an empty range or zero sigma forces zero heat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            kill_reg <= 1'b0;
        else
            kill_reg <= (range_x <= 0) || (range_y <= 0) || (range_z <= 0) ||
                        (spread_x_reg == '0) || (spread_y_reg == '0) ||
                        (SPREAD_DEPTH == 0);
    end

    always_ff @(posedge clk)
    begin
        div_x_reg <= range_x[MAG_W-1:0];
        div_y_reg <= range_y[MAG_W-1:0];
        div_z_reg <= range_z[MAG_W-1:0];
        den_x_reg <= DEN_W'({(DEN_W-1)'(spread_x_reg) * (DEN_W-1)'(spread_x_reg), 1'b0});
        den_y_reg <= DEN_W'({(DEN_W-1)'(spread_y_reg) * (DEN_W-1)'(spread_y_reg), 1'b0});
    end

    // the whole pipeline advances unless the skid register holds a word
    assign en       = !skid_valid_reg;
    assign in_ready = en;

    assign ctl_in     = '{en: en, valid: in_valid};
    assign ctl_axis   = '{en: en, valid: vx};
    assign ctl_axis_y = '{en: en, valid: vy};
    assign ctl_axis_z = '{en: en, valid: vz};
    assign ctl_sum    = '{en: en, valid: vsum_reg};

    ghv_norm u_norm_x (
        .clk, .rst_n, .ctl(ctl_in), .raw(joint_x), .low(x_low_reg),
        .divisor(div_x_reg), .tag_in(column), .out_valid(vx), .g(gx), .tag_out(tx)
    );

    ghv_norm u_norm_y (
        .clk, .rst_n, .ctl(ctl_in), .raw(joint_y), .low(y_low_reg),
        .divisor(div_y_reg), .tag_in(row), .out_valid(vy), .g(gy), .tag_out(ty)
    );

    ghv_norm u_norm_z (
        .clk, .rst_n, .ctl(ctl_in), .raw(joint_depth), .low(depth_low_reg),
        .divisor(div_z_reg), .tag_in(layer), .out_valid(vz), .g(gz), .tag_out(tz)
    );

    // the three lanes run in lockstep, each with its own valid bits
    ghv_axis u_axis_x (
        .clk, .rst_n, .ctl(ctl_axis), .g(gx), .pos(map_tab[tx]),
        .den(den_x_reg), .out_valid(vax), .e(ex)
    );

    ghv_axis u_axis_y (
        .clk, .rst_n, .ctl(ctl_axis_y), .g(gy), .pos(map_tab[ty]),
        .den(den_y_reg), .out_valid(vay), .e(ey)
    );

    ghv_axis u_axis_z (
        .clk, .rst_n, .ctl(ctl_axis_z), .g(gz), .pos(layer_tab[tz]),
        .den(DEN_Z), .out_valid(vaz), .e(ez)
    );

    // sum the per-axis exponents
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vsum_reg <= 1'b0;
        else if (en)
            vsum_reg <= vax & vay & vaz;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            esum_reg <= ESUM_W'(ex) + ESUM_W'(ey) + ESUM_W'(ez);
    end

    ghv_nexp u_nexp (
        .clk, .rst_n, .ctl(ctl_sum), .e(esum_reg[EXP_W-1:0]),
        .zero_in(esum_reg > ESUM_W'(EXP_LIMIT)),
        .out_valid(pipe_valid), .val(pipe_val), .zero_out(pipe_zero)
    );

    assign pipe_heat = (pipe_zero || kill_reg) ? '0 : pipe_val;

    // output register with one skid word behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg <= pipe_valid;
        end
        else if (pipe_valid)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ready)
            heat_reg <= skid_valid_reg ? skid_heat_reg : pipe_heat;
        else if (en && pipe_valid)
            skid_heat_reg <= pipe_heat;
    end

    assign out_valid = out_valid_reg;
    assign heat      = heat_reg;

endmodule
